### rtl/jsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsd_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int MAX_SLOTS = 16;

    localparam int ID_W       = 8;
    localparam int DUE_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 20;
    localparam int SLOT_OUT_W = 4;

    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CMP_W = ((SLOT_W > DUE_W) ? SLOT_W : DUE_W) + 1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DUE_W-1:0]  due;
        logic [GAIN_W-1:0] gain;
    } job_t;

    typedef struct packed {
        logic ins;
        logic pop;
        job_t new_job;
    } chain_ctl_t;

    typedef struct packed {
        logic              clr;
        logic              place;
        job_t              job;
        logic [SLOT_W-1:0] rd_idx;
    } slot_ctl_t;

endpackage

`default_nettype wire

### rtl/job_sequencing_with_deadlines_core.sv
// channel | dir | ports                      | payload
// --------+-----+----------------------------+---------------------------------------
// job in  | in  | s_tvalid s_tready s_tdata  | tdata: job_id, due_slot, gain; tlast: last_job
//         |     | s_tlast                    |
// result  | out | m_tvalid m_tready m_tdata  | tdata: job_id_res, slot_index, total_gain;
//         |     | m_tuser m_tlast            | tuser: is_job; tlast: last_result
//
// load: one job transfer per cycle into the sorted cell chain
// schedule: jobs leave the chain head in gain order for the slot search until it is empty
// output: occupied slots in slot order, then the summary result; held by m_tready stalls
// s_tready is low from the last job until the summary is loaded in the output register
// reset: synchronous, clears counts, slot occupancy, total and the output valid flag
`timescale 1ns / 1ps
`default_nettype none

module job_sequencing_with_deadlines_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // job_id[7:0], due_slot[15:8], gain[31:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // job_id_res[7:0], slot_index[11:8], total_gain[31:12]
    output logic             m_tuser,   // is_job
    output logic             m_tlast
);
    import jsd_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCHED = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;
    logic              out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    chain_ctl_t        chain_ctl;
    slot_ctl_t         slot_ctl;
    job_t              head_job;
    logic              head_valid;
    logic              rd_occ;
    logic [ID_W-1:0]   rd_id;
    logic [SUM_W-1:0]  sum;
    logic              s_xfer;
    logic              out_free;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        chain_ctl.new_job.id   = s_tdata[7:0];
        chain_ctl.new_job.due  = s_tdata[15:8];
        chain_ctl.new_job.gain = s_tdata[31:16];
        chain_ctl.ins          = s_xfer;
        chain_ctl.pop          = (state_reg == ST_SCHED);

        slot_ctl.clr    = s_xfer && s_tlast;
        slot_ctl.place  = (state_reg == ST_SCHED) && head_valid;
        slot_ctl.job    = head_job;
        slot_ctl.rd_idx = ptr_reg;
    end

    jsd_sort_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (chain_ctl),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    jsd_slots u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (slot_ctl),
        .rd_occ  (rd_occ),
        .rd_id   (rd_id),
        .sum     (sum)
    );

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_xfer && s_tlast) begin
                    state_next = ST_SCHED;
                end
            end
            ST_SCHED: begin
                ptr_next = '0;
                if (!head_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (rd_occ) begin
                        out_valid_next = 1'b1;
                        out_data_next  = {{SUM_W{1'b0}}, SLOT_OUT_W'(ptr_reg), rd_id};
                        out_user_next  = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    if (ptr_reg == SLOT_W'(MAX_SLOTS - 1)) begin
                        state_next = ST_SUM;
                    end else begin
                        ptr_next = ptr_reg + SLOT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {sum, {(32-SUM_W){1'b0}}};
                    out_user_next  = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_last_starts_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_SCHED))
        else $error("schedule did not start after final job");

    a_summary_not_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("summary result flagged as job");

    a_job_no_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:12] == '0 && !m_tlast))
        else $error("job result carries total or last mark");

    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCHED && head_valid) |=> (state_reg == ST_SCHED || !head_valid))
        else $error("left scheduling with jobs pending");

endmodule

`default_nettype wire

### rtl/jsd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module jsd_cell (
    input  wire logic               aclk,
    input  wire jsd_pkg::chain_ctl_t ctl,
    input  wire logic               valid_i,
    input  wire logic               prev_ge_i,
    input  wire jsd_pkg::job_t      prev_job_i,
    input  wire jsd_pkg::job_t      next_job_i,
    output jsd_pkg::job_t           job_o,
    output logic                    ge_o
);
    import jsd_pkg::*;

    job_t job_reg;
    job_t job_next;

    // this entry ranks ahead of the incoming job (ties keep arrival order)
    assign ge_o  = valid_i && (job_reg.gain >= ctl.new_job.gain);
    assign job_o = job_reg;

    always_comb begin
        job_next = job_reg;
        if (ctl.pop) begin
            job_next = next_job_i;
        end else if (ctl.ins && !ge_o) begin
            job_next = prev_ge_i ? ctl.new_job : prev_job_i;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

### rtl/jsd_sort_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module jsd_sort_chain (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire jsd_pkg::chain_ctl_t ctl,
    output jsd_pkg::job_t            head_job,
    output logic                     head_valid
);
    import jsd_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    chain_ctl_t       cell_ctl;
    job_t             cell_job [MAX_JOBS];
    logic             cell_ge  [MAX_JOBS];
    logic             cell_valid [MAX_JOBS];
    job_t             blank_job;

    assign full       = (count_reg == CNT_W'(MAX_JOBS));
    assign head_valid = (count_reg != '0);
    assign head_job   = cell_job[0];
    assign blank_job  = '0;

    always_comb begin
        cell_ctl     = ctl;
        cell_ctl.ins = ctl.ins && !full && !ctl.pop;
        cell_ctl.pop = ctl.pop && head_valid;
        count_next   = count_reg;
        if (cell_ctl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cell_ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        assign cell_valid[i] = (count_reg > CNT_W'(i));
        jsd_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .valid_i    (cell_valid[i]),
            .prev_ge_i  ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i-1]),
            .prev_job_i ((i == 0) ? blank_job : cell_job[(i == 0) ? 0 : i-1]),
            .next_job_i ((i == MAX_JOBS-1) ? blank_job
                                            : cell_job[(i == MAX_JOBS-1) ? i : i+1]),
            .job_o      (cell_job[i]),
            .ge_o       (cell_ge[i])
        );
    end

endmodule

`default_nettype wire

### rtl/jsd_slots.sv
`timescale 1ns / 1ps
`default_nettype none

module jsd_slots (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire jsd_pkg::slot_ctl_t   ctl,
    output logic                      rd_occ,
    output logic [jsd_pkg::ID_W-1:0]  rd_id,
    output logic [jsd_pkg::SUM_W-1:0] sum
);
    import jsd_pkg::*;

    logic [MAX_SLOTS-1:0] occ_reg;
    logic [MAX_SLOTS-1:0] occ_next;
    logic [ID_W-1:0]      id_reg [MAX_SLOTS];
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W:0]       sum_add;
    logic                 found;
    logic [SLOT_W-1:0]    sel;

    // latest free slot before the deadline
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (!occ_reg[s] && (SLOT_CMP_W'(s) < SLOT_CMP_W'(ctl.job.due))) begin
                found = 1'b1;
                sel   = SLOT_W'(s);
            end
        end
    end

    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(ctl.job.gain);

    always_comb begin
        occ_next = occ_reg;
        sum_next = sum_reg;
        if (ctl.clr) begin
            occ_next = '0;
            sum_next = '0;
        end else if (ctl.place && found) begin
            occ_next[sel] = 1'b1;
            sum_next      = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            sum_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clr && ctl.place && found) begin
            id_reg[sel] <= ctl.job.id;
        end
    end

    assign rd_occ = occ_reg[ctl.rd_idx];
    assign rd_id  = id_reg[ctl.rd_idx];
    assign sum    = sum_reg;

endmodule

`default_nettype wire

### test/job_sequencing_with_deadlines_core_tb.sv
`timescale 1ns / 1ps

module job_sequencing_with_deadlines_core_tb;

    import jsd_pkg::*;

    typedef struct {
        logic              is_job;
        logic [ID_W-1:0]   job_id;
        logic [3:0]        slot;
        logic [SUM_W-1:0]  total;
        logic              last;
    } sched_result_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_ALTERNATE,
        RDY_RANDOM,
        RDY_LONG_STALL
    } rdy_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    job_t          pending_jobs[$];
    sched_result_t sched_results[$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    bit            quiet_sender = 1'b0;
    rdy_mode_t     rdy_mode = RDY_ALWAYS;
    int            rdy_cycle = 0;

    job_sequencing_with_deadlines_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // greedy schedule of the stored set, results queued in slot order
    function automatic void schedule_jobs();
        int            order[$];
        int            owner[MAX_SLOTS];
        int            pos;
        int            lim;
        int            total;
        bit            placed;
        sched_result_t r;
        for (int i = 0; i < pending_jobs.size(); i++) begin
            pos = order.size();
            while (pos > 0 && pending_jobs[order[pos-1]].gain < pending_jobs[i].gain)
                pos--;
            order.insert(pos, i);
        end
        for (int s = 0; s < MAX_SLOTS; s++)
            owner[s] = -1;
        total = 0;
        for (int i = 0; i < order.size(); i++) begin
            lim = (pending_jobs[order[i]].due > MAX_SLOTS) ? MAX_SLOTS
                                                            : int'(pending_jobs[order[i]].due);
            placed = 1'b0;
            for (int s = lim; s > 0 && !placed; s--) begin
                if (owner[s-1] < 0) begin
                    owner[s-1] = order[i];
                    placed = 1'b1;
                    total += pending_jobs[order[i]].gain;
                    if (total > (1 << SUM_W) - 1)
                        total = (1 << SUM_W) - 1;
                end
            end
        end
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (owner[s] >= 0) begin
                r.is_job = 1'b1;
                r.job_id = pending_jobs[owner[s]].id;
                r.slot   = s[3:0];
                r.total  = '0;
                r.last   = 1'b0;
                sched_results.push_back(r);
            end
        end
        r.is_job = 1'b0;
        r.job_id = '0;
        r.slot   = '0;
        r.total  = total[SUM_W-1:0];
        r.last   = 1'b1;
        sched_results.push_back(r);
        pending_jobs.delete();
    endfunction

    function automatic void record_job(input job_t j, input logic last);
        if (pending_jobs.size() < MAX_JOBS)
            pending_jobs.push_back(j);
        if (last)
            schedule_jobs();
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_job(input logic [ID_W-1:0] id, input logic [DUE_W-1:0] due,
                            input logic [GAIN_W-1:0] gain, input logic last);
        int   gap;
        job_t j;
        if (burst_left == 0) begin
            gap = quiet_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {gain, due, id};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        j.id   = id;
        j.due  = due;
        j.gain = gain;
        record_job(j, last);
    endtask

    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (sched_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_single_job;
        send_job(8'hFF, 8'd1, 16'hFFFF, 1'b1);
    endtask

    task automatic test_zero_deadline;
        send_job(8'h00, 8'd0, 16'hFFFF, 1'b0);
        send_job(8'h55, 8'd3, 16'h0000, 1'b1);
    endtask

    task automatic test_deadline_saturation;
        send_job(8'h01, 8'd255, 16'd10, 1'b0);
        send_job(8'h02, 8'd16, 16'd20, 1'b0);
        send_job(8'h03, 8'd17, 16'd30, 1'b0);
        send_job(8'h04, 8'd200, 16'd5, 1'b1);
    endtask

    task automatic test_equal_gains;
        send_job(8'h10, 8'd1, 16'd500, 1'b0);
        send_job(8'h11, 8'd1, 16'd500, 1'b0);
        send_job(8'h12, 8'd2, 16'd500, 1'b1);
    endtask

    // 16 jobs fill the store, the closing transfer is dropped but starts the run
    task automatic test_full_store;
        for (int k = 0; k < MAX_JOBS; k++)
            send_job(8'h20 + k[7:0], 8'(k % 18), 16'(1000 + 37 * k), 1'b0);
        send_job(8'hEE, 8'd1, 16'hFFFF, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_sets;
        int               sent;
        int               set_len;
        logic [DUE_W-1:0] due;
        logic [GAIN_W-1:0] gain;
        sent = 0;
        while (sent < 130) begin
            quiet_sender = ($urandom_range(0, 3) == 0);
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < set_len; k++) begin
                if ($urandom_range(0, 4) == 0)
                    due = DUE_W'($urandom_range(0, 255));
                else
                    due = DUE_W'($urandom_range(0, MAX_SLOTS + 2));
                if ($urandom_range(0, 1) == 0)
                    gain = GAIN_W'($urandom_range(0, 65535));
                else
                    gain = 16'($urandom_range(0, 3)) << 14;
                send_job(ID_W'($urandom_range(0, 255)), due, gain, k == set_len - 1);
            end
            sent += set_len;
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end
        quiet_sender = 1'b0;
    endtask

    // receiver stall pattern, with rdy_mode redrawn at random as rdy_cycle advances
    always @(posedge aclk) begin
        rdy_cycle <= rdy_cycle + 1;
        if (rdy_cycle % 64 == 0)
            rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
        case (rdy_mode)
            RDY_ALWAYS:     m_tready <= 1'b1;
            RDY_ALTERNATE:  m_tready <= (rdy_cycle % 2 == 1);
            RDY_RANDOM:     m_tready <= ($urandom_range(0, 9) < 7);
            RDY_LONG_STALL: m_tready <= (rdy_cycle % 24 < 4);
            default:        m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sched_results.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata, 0);
            end else begin
                want = sched_results.pop_front();
                if (m_tuser !== want.is_job)
                    report_mismatch("is_job", m_tuser, want.is_job);
                if (m_tdata[7:0] !== want.job_id)
                    report_mismatch("job_id_res", m_tdata[7:0], want.job_id);
                if (m_tdata[11:8] !== want.slot)
                    report_mismatch("slot_index", m_tdata[11:8], want.slot);
                if (m_tdata[31:12] !== want.total)
                    report_mismatch("total_gain", m_tdata[31:12], want.total);
                if (m_tlast !== want.last)
                    report_mismatch("last_result", m_tlast, want.last);
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_job();
        test_zero_deadline();
        test_deadline_saturation();
        test_equal_gains();
        test_full_store();
        test_random_sets();
        s_tvalid <= 1'b0;
        while (sched_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### job_sequencing_with_deadlines_core.f
rtl/jsd_pkg.sv
rtl/jsd_cell.sv
rtl/jsd_sort_chain.sv
rtl/jsd_slots.sv
rtl/job_sequencing_with_deadlines_core.sv
test/job_sequencing_with_deadlines_core_tb.sv
